/* src/fvn_pkg.sv */
// Shared types, constants and the ease-table function for the fractal value noise block.
// Used by every module under src; depends on nothing else.
package fvn_pkg;

   localparam int EASE_TABLE_BITS_DEF = 10;
   localparam int MAX_OCTAVES_DEF     = 10;
   localparam int QUEUE_DEPTH         = 4;

   localparam int COORD_W = 32;
   localparam int LAT_W   = 30;   // lattice, smoothed and blended values
   localparam int ACC_W   = 31;   // octave sum stays below 2^29 in magnitude
   localparam int WGT_W   = 17;   // ease weight, 0..65536
   localparam int TAG_W   = 4;    // sixteen lattice points per octave
   localparam int CFG_W   = 4;

   localparam logic [31:0] HASH_Y_MUL  = 32'd156693;
   localparam logic [31:0] HASH_N_MUL  = 32'd1087;
   localparam logic [31:0] HASH_SQ_MUL = 32'd15731;
   localparam logic [31:0] HASH_ADD0   = 32'd789221;
   localparam logic [31:0] HASH_ADD1   = 32'd1376312589;
   localparam logic [31:0] HASH_MASK   = 32'h7fff_ffff;
   localparam logic [32:0] ONE_Q30     = 33'd1073741824;
   localparam logic [12:0] LAT_SCALE   = 13'd3433;
   localparam longint unsigned PI_Q30  = 64'd3373259426;
   localparam logic [WGT_W-1:0] WGT_ONE = 17'd65536;

   localparam logic [CFG_W-1:0] OCTAVE_RESET = 4'd10;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_x;
   } point_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [31:0]      x;
      logic [31:0]      y;
   } hash_req_type;

   typedef struct packed {
      logic                    valid;
      logic [TAG_W-1:0]        tag;
      logic signed [LAT_W-1:0] value;
   } hash_rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE, BK_SETUP, BK_ISSUE, BK_DRAIN, BK_ROWS,
      BK_COLS, BK_MUL, BK_SUM, BK_ACC, BK_DONE
   } back_state_type;

   // Squared sine ease weight in Q16 for table entry k, sine taken by a series in Q30.
   function automatic logic [WGT_W-1:0] ease_entry(input longint unsigned k,
                                                   input int unsigned bits);
      longint unsigned phi;
      longint unsigned phi2;
      longint unsigned term;
      longint unsigned tmp;
      longint unsigned sq;
      longint          sum;
      int              n;
      phi  = (PI_Q30 * k) >> (bits + 1);
      phi2 = (phi * phi) >> 30;
      term = phi;
      sum  = longint'(phi);
      for (n = 1; n <= 8; n++) begin
         tmp = (term * phi2) >> 30;
         case (n)
            1: term = tmp / 64'd6;
            2: term = tmp / 64'd20;
            3: term = tmp / 64'd42;
            4: term = tmp / 64'd72;
            5: term = tmp / 64'd110;
            6: term = tmp / 64'd156;
            7: term = tmp / 64'd210;
            default: term = tmp / 64'd272;
         endcase
         if (n % 2 == 1) sum = sum - longint'(term);
         else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > 64'sd1073741824) sum = 64'sd1073741824;
      sq = (longint'(sum) * longint'(sum)) >> 30;
      return WGT_W'((sq + 64'd8192) >> 14);
   endfunction

endpackage

/* src/fvn_front.sv */
// Front end: accepts coordinate items and holds them in a short queue for the back end.
// Depends on fvn_pkg.
module fvn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [63:0]       req_tdata,
   output logic              pt_valid,
   input  logic              pt_ready,
   output fvn_pkg::point_type pt
);
   import fvn_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   point_type        queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pt_valid   = (count_ff != '0);
   assign pt         = queue_ff[rd_ptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = pt_valid && pt_ready;

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = CNT_W'(count_ff + 1'b1);
      if (pop && !push) count_in = CNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= point_type'({req_tdata[63:32], req_tdata[31:0]});
      end
   end

endmodule

/* src/fvn_hash.sv */
// Seven-stage pipelined lattice hash: integer corner in, scaled lattice value out.
// Depends on fvn_pkg.
module fvn_hash (
   input  logic                  clock,
   input  logic                  reset,
   input  fvn_pkg::hash_req_type req_in,
   output fvn_pkg::hash_rsp_type rsp_out
);
   import fvn_pkg::*;

   localparam int STAGES = 7;

   logic             valid_ff [STAGES];
   logic [TAG_W-1:0] tag_ff   [STAGES];

   logic [31:0] x1_ff, m1_ff, n2_ff, n3_ff, n4_ff, sq4_ff, n5_ff, p5_ff, t6_ff;
   logic signed [LAT_W-1:0] v7_ff;

   logic [63:0] m1_in, nm_in, sq_in, p_in, t_in;
   logic [31:0] n2_in;
   logic signed [33:0] d_in;
   logic signed [47:0] scaled_in;

   always_comb begin
      m1_in     = req_in.y * 64'(HASH_Y_MUL);
      n2_in     = x1_ff + m1_ff;
      nm_in     = n2_ff * 64'(HASH_N_MUL);
      sq_in     = n3_ff * n3_ff;
      p_in      = sq4_ff * 64'(HASH_SQ_MUL);
      t_in      = n5_ff * p5_ff;
      d_in      = $signed({1'b0, ONE_Q30}) - $signed({2'b00, t6_ff});
      scaled_in = d_in * $signed({1'b0, LAT_SCALE});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) valid_ff[s] <= 1'b0;
      end else begin
         valid_ff[0] <= req_in.valid;
         for (int s = 1; s < STAGES; s++) valid_ff[s] <= valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      tag_ff[0] <= req_in.tag;
      for (int s = 1; s < STAGES; s++) tag_ff[s] <= tag_ff[s-1];
      x1_ff  <= req_in.x;
      m1_ff  <= m1_in[31:0];
      n2_ff  <= n2_in;
      n3_ff  <= (n2_ff << 13) ^ nm_in[31:0];
      n4_ff  <= n3_ff;
      sq4_ff <= sq_in[31:0];
      n5_ff  <= n4_ff;
      p5_ff  <= p_in[31:0] + HASH_ADD0;
      t6_ff  <= (t_in[31:0] + HASH_ADD1) & HASH_MASK;
      v7_ff  <= LAT_W'(scaled_in >>> 14);
   end

   assign rsp_out.valid = valid_ff[STAGES-1];
   assign rsp_out.tag   = tag_ff[STAGES-1];
   assign rsp_out.value = v7_ff;

endmodule

/* src/fvn_back.sv */
// Back end: octave sequencer, ease ROM, smoothing, blending and accumulation.
// Depends on fvn_pkg and instantiates fvn_hash.
module fvn_back #(
   parameter int EASE_TABLE_BITS = fvn_pkg::EASE_TABLE_BITS_DEF,
   parameter int MAX_OCTAVES     = fvn_pkg::MAX_OCTAVES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      pt_valid,
   output logic                      pt_ready,
   input  fvn_pkg::point_type        pt,
   input  logic [fvn_pkg::CFG_W-1:0] octave_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [31:0]               rsp_data
);
   import fvn_pkg::*;

   localparam int EASE_SIZE = 1 << EASE_TABLE_BITS;
   localparam int OCT_W     = $clog2(MAX_OCTAVES + 1);
   localparam int SX_W      = COORD_W + MAX_OCTAVES;
   localparam int PROD_W    = LAT_W + WGT_W + 1;
   localparam int GRID_N    = 16;

   typedef logic [EASE_SIZE-1:0][WGT_W-1:0] ease_rom_type;

   function automatic ease_rom_type build_ease_rom();
      ease_rom_type rom;
      for (int k = 0; k < EASE_SIZE; k++) begin
         rom[k] = ease_entry(longint'(k), EASE_TABLE_BITS);
      end
      return rom;
   endfunction

   localparam ease_rom_type EASE_ROM = build_ease_rom();

   back_state_type state_ff, state_in;

   point_type               pt_ff;
   logic [OCT_W-1:0]        oct_ff, noct_ff;
   logic [31:0]             ix_ff, iy_ff;
   logic [EASE_TABLE_BITS-1:0] fxi_ff, fyi_ff, rom_addr;
   logic [WGT_W-1:0]        ease_q_ff, wx_ff, wy_ff;
   logic [TAG_W-1:0]        issue_ff;
   logic [TAG_W:0]          recv_ff;
   logic signed [LAT_W-1:0] grid_ff [GRID_N];
   logic signed [LAT_W+1:0] rows_ff [4][2];
   logic signed [LAT_W-1:0] sm_ff   [2][2];
   logic [1:0]              step_ff;
   logic signed [PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic signed [LAT_W-1:0] r0_ff, r1_ff, noise_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic                    rsp_valid_ff;
   logic [31:0]             rsp_data_ff;

   hash_req_type hreq;
   hash_rsp_type hrsp;

   // Integer part and table index for the current octave.
   logic signed [SX_W-1:0] sx, sy;
   logic [SX_W-1:0]        mag_x, mag_y, q_x, q_y;
   logic [SX_W-1:0]        iq_x, iq_y;

   always_comb begin
      sx    = $signed({{MAX_OCTAVES{pt_ff.coord_x[COORD_W-1]}}, pt_ff.coord_x}) <<< oct_ff;
      sy    = $signed({{MAX_OCTAVES{pt_ff.coord_y[COORD_W-1]}}, pt_ff.coord_y}) <<< oct_ff;
      mag_x = sx[SX_W-1] ? SX_W'(-sx) : SX_W'(sx);
      mag_y = sy[SX_W-1] ? SX_W'(-sy) : SX_W'(sy);
      q_x   = mag_x >> 16;
      q_y   = mag_y >> 16;
      iq_x  = sx[SX_W-1] ? SX_W'(-q_x) : q_x;
      iq_y  = sy[SX_W-1] ? SX_W'(-q_y) : q_y;
   end

   // Blend operands by step: both x blends use wx, the final y blend uses wy.
   logic signed [LAT_W-1:0] bl_a, bl_b;
   logic [WGT_W-1:0]        bl_w;
   logic signed [PROD_W:0]  bl_sum;

   always_comb begin
      case (step_ff)
         2'd0: begin
            bl_a = sm_ff[0][0]; bl_b = sm_ff[0][1]; bl_w = wx_ff;
         end
         2'd1: begin
            bl_a = sm_ff[1][0]; bl_b = sm_ff[1][1]; bl_w = wx_ff;
         end
         default: begin
            bl_a = r0_ff; bl_b = r1_ff; bl_w = wy_ff;
         end
      endcase
      bl_sum = (PROD_W+1)'(prod_a_ff) + (PROD_W+1)'(prod_b_ff);
   end

   assign hreq.valid = (state_ff == BK_ISSUE);
   assign hreq.tag   = issue_ff;
   assign hreq.x     = ix_ff + 32'(issue_ff[1:0]) - 32'd1;
   assign hreq.y     = iy_ff + 32'(issue_ff[3:2]) - 32'd1;
   assign rom_addr   = (issue_ff == '0) ? fxi_ff : fyi_ff;

   fvn_hash u_hash (
      .clock   (clock),
      .reset   (reset),
      .req_in  (hreq),
      .rsp_out (hrsp)
   );

   logic [OCT_W-1:0] noct_sel;
   assign noct_sel = (32'(octave_count) > MAX_OCTAVES) ? OCT_W'(MAX_OCTAVES)
                                                      : OCT_W'(octave_count);
   assign pt_ready = (state_ff == BK_IDLE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:  if (pt_valid) state_in = (noct_sel == '0) ? BK_DONE : BK_SETUP;
         BK_SETUP: state_in = BK_ISSUE;
         BK_ISSUE: if (issue_ff == '1) state_in = BK_DRAIN;
         BK_DRAIN: if (recv_ff == (TAG_W+1)'(GRID_N)) state_in = BK_ROWS;
         BK_ROWS:  state_in = BK_COLS;
         BK_COLS:  state_in = BK_MUL;
         BK_MUL:   state_in = BK_SUM;
         BK_SUM:   state_in = (step_ff == 2'd2) ? BK_ACC : BK_MUL;
         BK_ACC:   state_in = (OCT_W'(oct_ff + 1'b1) == noct_ff) ? BK_DONE : BK_SETUP;
         BK_DONE:  if (!rsp_valid_ff || rsp_ready) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_DONE && (!rsp_valid_ff || rsp_ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      ease_q_ff <= EASE_ROM[rom_addr];
      if (hrsp.valid) grid_ff[hrsp.tag] <= hrsp.value;
      case (state_ff)
         BK_IDLE: begin
            pt_ff   <= pt;
            noct_ff <= noct_sel;
            oct_ff  <= '0;
            acc_ff  <= '0;
         end
         BK_SETUP: begin
            ix_ff    <= iq_x[31:0];
            iy_ff    <= iq_y[31:0];
            fxi_ff   <= mag_x[15 -: EASE_TABLE_BITS];
            fyi_ff   <= mag_y[15 -: EASE_TABLE_BITS];
            issue_ff <= '0;
            recv_ff  <= '0;
            step_ff  <= '0;
         end
         BK_ISSUE: begin
            issue_ff <= TAG_W'(issue_ff + 1'b1);
            if (issue_ff == TAG_W'(1)) wx_ff <= ease_q_ff;
            if (issue_ff == TAG_W'(2)) wy_ff <= ease_q_ff;
         end
         BK_ROWS: begin
            for (int r = 0; r < 4; r++) begin
               for (int c = 0; c < 2; c++) begin
                  rows_ff[r][c] <= (LAT_W+2)'(grid_ff[r*4+c])
                                 + ((LAT_W+2)'(grid_ff[r*4+c+1]) <<< 1)
                                 + (LAT_W+2)'(grid_ff[r*4+c+2]);
               end
            end
         end
         BK_COLS: begin
            for (int b = 0; b < 2; b++) begin
               for (int a = 0; a < 2; a++) begin
                  sm_ff[b][a] <= LAT_W'(((LAT_W+4)'(rows_ff[b][a])
                                        + ((LAT_W+4)'(rows_ff[b+1][a]) <<< 1)
                                        + (LAT_W+4)'(rows_ff[b+2][a])) >>> 4);
               end
            end
         end
         BK_MUL: begin
            prod_a_ff <= bl_a * $signed({1'b0, WGT_W'(WGT_ONE - bl_w)});
            prod_b_ff <= bl_b * $signed({1'b0, bl_w});
         end
         BK_SUM: begin
            step_ff <= 2'(step_ff + 1'b1);
            case (step_ff)
               2'd0:    r0_ff    <= LAT_W'(bl_sum >>> 16);
               2'd1:    r1_ff    <= LAT_W'(bl_sum >>> 16);
               default: noise_ff <= LAT_W'(bl_sum >>> 16);
            endcase
         end
         BK_ACC: begin
            acc_ff <= ACC_W'(acc_ff + ACC_W'(noise_ff >>> oct_ff));
            oct_ff <= OCT_W'(oct_ff + 1'b1);
         end
         BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) rsp_data_ff <= 32'(acc_ff);
         end
         default: begin
         end
      endcase
      if (state_ff == BK_DRAIN || state_ff == BK_ISSUE) begin
         if (hrsp.valid) recv_ff <= (TAG_W+1)'(recv_ff + 1'b1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* src/fractal_value_noise_2d.sv */
// Top level of the fractal 2D value noise block: channels, octave register, assertions.
// Depends on fvn_pkg, fvn_front, fvn_hash and fvn_back.
//
// Usage. A point enters on the req_ channel as two signed Q16.16 coordinates and
// leaves on the rsp_ channel as one signed Q16.16 noise sum, one result item for
// every input item, in order. The octave count (0 to 10 in use) is written on
// the csr_ channel while the block is idle; csr_ready is always high.
//
// Operation. For each octave the back end scales the point, feeds the sixteen
// lattice corners one a cycle into the seven-stage hash pipeline, drains it,
// smooths the rows and then the columns, runs the three blends (multiply then
// add) and accumulates. The back end takes a new item only when it is through
// with the last one, and it drains the shared hash pipeline each octave. A
// four-item queue in front keeps taking items while the back end works, and the
// result register lets the next item start while a result still waits for
// rsp_tready. A stalled receiver backs up the result register, then the back
// end, then the queue, and only then req_tready.
// Reset clears all queues and pipelines and sets the octave count to ten.
module fractal_value_noise_2d #(
   parameter int EASE_TABLE_BITS = fvn_pkg::EASE_TABLE_BITS_DEF,
   parameter int MAX_OCTAVES     = fvn_pkg::MAX_OCTAVES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,   // coord_x [31:0], coord_y [63:32]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [31:0]               rsp_tdata,   // noise_value [31:0]
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [fvn_pkg::CFG_W-1:0] csr_data     // octave_count [3:0]
);
   import fvn_pkg::*;

   logic [CFG_W-1:0] octave_ff;
   logic             pt_valid, pt_ready;
   point_type        pt;

   assign csr_ready = 1'b1;

   // Octave count register, unchecked: write it only while no item is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff <= OCTAVE_RESET;
      end else if (csr_valid && csr_ready) begin
         octave_ff <= csr_data;
      end
   end

   fvn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pt_valid   (pt_valid),
      .pt_ready   (pt_ready),
      .pt         (pt)
   );

   fvn_back #(
      .EASE_TABLE_BITS (EASE_TABLE_BITS),
      .MAX_OCTAVES     (MAX_OCTAVES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .pt_valid     (pt_valid),
      .pt_ready     (pt_ready),
      .pt           (pt),
      .octave_count (octave_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_data     (rsp_tdata)
   );

   // Once the back end takes an item from the queue it is busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      pt_valid && pt_ready |=> !pt_ready)
      else $error("back end took two items in successive cycles");

   // A full queue always offers an item to the back end.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> pt_valid)
      else $error("queue refuses items while holding none");

endmodule

/* tb/fractal_value_noise_2d_tb.sv */
// Self-checking testbench for the fractal 2D value noise block.
// It needs fvn_pkg and the RTL under src. It drives points on the req_ stream and
// writes the octave count on csr_. Every rsp_ item is checked against a predictor.
`timescale 1ns / 1ps

// Keeps the expected noise sums and predicts them from the octave count.
class noise_checker;
   typedef struct {
      bit signed [31:0] x;
      bit signed [31:0] y;
      bit signed [31:0] noise;
   } noise_expect_type;

   noise_expect_type pending_noise[$];
   bit [3:0]      octaves;
   longint        ease_tab[1025];
   int            mismatches;
   int            checked;

   function new();
      longint unsigned phi, phi2, term, sq;
      longint          sum;
      octaves    = fvn_pkg::OCTAVE_RESET;
      mismatches = 0;
      checked    = 0;
      // Squared sine by a nine-term series in Q30, then rounded to Q16.
      for (int k = 0; k <= 1024; k++) begin
         phi  = (64'd3373259426 * k) >> 11;
         phi2 = (phi * phi) >> 30;
         term = phi;
         sum  = longint'(phi);
         for (int n = 1; n <= 8; n++) begin
            term = ((term * phi2) >> 30) / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) sum -= longint'(term);
            else            sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > 64'sd1073741824) sum = 64'sd1073741824;
         sq = (longint'(sum) * longint'(sum)) >> 30;
         ease_tab[k] = longint'((sq + 64'd8192) >> 14);
      end
   endfunction

   function longint lattice_value(bit [31:0] x, bit [31:0] y);
      bit [31:0] n, t;
      n = x + y * 32'd156693;
      n = (n << 13) ^ (n * 32'd1087);
      t = n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589;
      t &= 32'h7fff_ffff;
      return ((64'sd1073741824 - longint'(t)) * 3433) >>> 14;
   endfunction

   function longint smoothed_value(bit [31:0] x, bit [31:0] y);
      longint corners, sides;
      corners = lattice_value(x - 1, y - 1) + lattice_value(x + 1, y - 1) +
                lattice_value(x - 1, y + 1) + lattice_value(x + 1, y + 1);
      sides   = lattice_value(x - 1, y) + lattice_value(x + 1, y) +
                lattice_value(x, y - 1) + lattice_value(x, y + 1);
      return (corners + 2 * sides + 4 * lattice_value(x, y)) >>> 4;
   endfunction

   function longint eased_weight(longint f);
      longint mag;
      mag = (f < 0 ? -f : f) & 64'hffff;
      return ease_tab[mag >> 6];
   endfunction

   function longint mix(longint a, longint b, longint w);
      return (a * (65536 - w) + b * w) >>> 16;
   endfunction

   function longint octave_noise(longint cx, longint cy, int i);
      longint    sx, sy, qx, qy, wx, wy, r0, r1;
      bit [31:0] ix, iy;
      sx = cx * (64'sd1 << i);
      sy = cy * (64'sd1 << i);
      qx = sx / 65536;
      qy = sy / 65536;
      wx = eased_weight(sx - qx * 65536);
      wy = eased_weight(sy - qy * 65536);
      ix = qx[31:0];
      iy = qy[31:0];
      r0 = mix(smoothed_value(ix, iy), smoothed_value(ix + 1, iy), wx);
      r1 = mix(smoothed_value(ix, iy + 1), smoothed_value(ix + 1, iy + 1), wx);
      return mix(r0, r1, wy);
   endfunction

   function bit signed [31:0] fractal_sum(bit signed [31:0] x, bit signed [31:0] y);
      longint total;
      int     count;
      total = 0;
      count = (octaves > 10) ? 10 : octaves;
      for (int i = 0; i < count; i++)
         total += octave_noise(longint'(x), longint'(y), i) >>> i;
      if (total > 64'sd2147483647) total = 64'sd2147483647;
      if (total < -64'sd2147483648) total = -64'sd2147483648;
      return total[31:0];
   endfunction

   function void note_point(bit signed [31:0] x, bit signed [31:0] y);
      noise_expect_type e;
      e.x     = x;
      e.y     = y;
      e.noise = fractal_sum(x, y);
      pending_noise.push_back(e);
   endfunction

   function void check_noise(bit signed [31:0] got);
      noise_expect_type e;
      checked++;
      if (pending_noise.size() == 0) begin
         $display("%0t: unexpected noise item, expected none, got %h", $time, got);
         mismatches++;
         return;
      end
      e = pending_noise.pop_front();
      if (got !== e.noise) begin
         $display("%0t: noise_value for (%h,%h): expected %h, got %h",
                  $time, e.x, e.y, e.noise, got);
         mismatches++;
      end
   endfunction
endclass

module fractal_value_noise_2d_tb;
   import fvn_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;   // far beyond one ten-octave item plus a long stall
   localparam int SETTLE_CYCLES  = 400;     // longer than one ten-octave item takes
   localparam int PHASE_ITEMS    = 104;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [63:0]       req_tdata;   // coord_x [31:0], coord_y [63:32]
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;   // noise_value [31:0]
   logic              csr_valid;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_data;    // octave_count [3:0]

   noise_checker board = new();
   int   send_idle_pct;
   int   recv_idle_pct;
   int   hold_request;              // receiver hold-off asked for by the stimulus
   int   points_sent;
   int   quiet_cycles;

   fractal_value_noise_2d u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver drops tready at random, or for a whole stretch when a hold-off
   // is asked for. The stretch is counted here so the sender can keep offering.
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Results are taken at the rising edge where both handshake signals are high.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_noise(rsp_tdata);
   end

   // Watchdog: counts cycles with no item moving on any channel.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("fractal_value_noise_2d_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one point and hold it until the block takes it. Valid drops at the
   // next falling edge; a following call raises it again in the same step unless it first idles.
   task automatic send_point(input logic [31:0] x, input logic [31:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {y, x};
      do @(posedge clock); while (!req_tready);
      board.note_point(x, y);
      points_sent++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_for_results();
      while (board.pending_noise.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // The octave count is only written while the block is idle.
   task automatic write_octaves(input logic [3:0] count);
      wait_for_results();
      csr_valid = 1'b1;
      csr_data  = count;
      do @(posedge clock); while (!csr_ready);
      board.octaves = count;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random points: fully random words, small coordinates near the origin, and
   // points close to the wrap of the integer part.
   task automatic send_random_point();
      logic [31:0] x, y;
      case ($urandom_range(2))
         0: begin
            x = $urandom;
            y = $urandom;
         end
         1: begin
            x = $urandom_range(32'h0008_0000) - 32'h0004_0000;
            y = $urandom_range(32'h0008_0000) - 32'h0004_0000;
         end
         default: begin
            x = {$urandom_range(1) ? 16'h7fff : 16'h8000, 16'($urandom)};
            y = {$urandom_range(1) ? 16'h0000 : 16'hffff, 16'($urandom)};
            if ($urandom_range(1)) {x, y} = {y, x};
         end
      endcase
      send_point(x, y);
   endtask

   initial begin
      logic [3:0]  octave_plan[9] = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd6,
                                      4'd10, 4'd2, 4'd8, 4'd4};
      logic [31:0] corner_words[8] = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000,
                                       32'hffff_ffff, 32'h0000_ffff, 32'hffff_0000,
                                       32'h0001_0000, 32'h0000_8000};
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_valid     = 1'b0;
      csr_data      = '0;
      send_idle_pct = 37;
      recv_idle_pct = 51;
      hold_request  = 0;
      points_sent   = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed points at the reset octave count of ten: coordinate extremes,
      // fractions just under one and just below zero, and integer parts that
      // wrap once scaled by the upper octaves.
      for (int i = 0; i < 8; i += 2) begin
         send_point(corner_words[i], corner_words[i + 1]);
         send_point(corner_words[i + 1], corner_words[i]);
      end
      send_point(32'h7fff_ffff, 32'h7fff_ffff);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h0040_0000, 32'hffc0_0001);
      send_point(32'hffff_ffff, 32'h0000_0001);
      send_point(32'h0000_0400, 32'hffff_fc00);

      // Receiver holds off for a long stretch while points keep coming, so the
      // queue fills and req_tready drops.
      hold_request = 3000;
      repeat (12) send_random_point();

      // Each phase writes a new octave count, the extremes and the out-of-range
      // counts among them. The idling pattern changes every third phase.
      for (int p = 0; p < 9; p++) begin
         write_octaves(octave_plan[p]);
         send_idle_pct = (p < 3) ? 37 : (p < 6) ? 51 : 0;
         recv_idle_pct = (p < 3) ? 51 : (p < 6) ? 37 : 0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random_point();
            // Once, midway through the fifth phase, the sender waits until every result is back.
            if (n == PHASE_ITEMS / 2 && p == 4) wait_for_results();
         end
      end

      wait_for_results();
      $display("Covered %0d points over octave counts 0, 1, 2, 3, 4, 6, 8, 10 and 15,",
               points_sent);
      $display("random idling on both sides and a long receiver stall; %0d results checked.",
               board.checked);
      if (board.mismatches == 0 && board.pending_noise.size() == 0) begin
         $display("fractal_value_noise_2d_tb: clean");
      end else begin
         $display("fractal_value_noise_2d_tb: errors");
      end
      $finish;
   end
endmodule
